// ===== hdl/brvm_pkg.sv =====
package brvm_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned RegAw    = $clog2(RegCount);
  localparam int unsigned RegW     = 64;
  localparam int unsigned OffBits  = 16;
  localparam int unsigned ImmW     = 32;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);
  localparam int unsigned OperandN = 4;

  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutFieldW = RegW + 2 + OffBits;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;

  localparam logic [7:0] OpcHalt = 8'h00;
  localparam logic [7:0] OpcAdd  = 8'h37;
  localparam logic [7:0] OpcSub  = 8'h6E;
  localparam logic [7:0] OpcMul  = 8'h83;
  localparam logic [7:0] OpcLoad = 8'h49;
  localparam logic [7:0] OpcNop  = 8'hC3;

  typedef enum logic [1:0] {
    AluLoad,
    AluAdd,
    AluSub,
    AluMul
  } alu_op_e;

  typedef enum logic [1:0] {
    StopEnd,
    StopHalt,
    StopUnknown,
    StopTrunc
  } stop_reason_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkExec,
    BkMulWb,
    BkFinish
  } back_state_e;

  // one queue entry: an instruction to run, a program end to report, or both
  typedef struct packed {
    logic                do_exec;
    logic                do_fin;
    alu_op_e             op;
    logic [RegAw-1:0]    rd;
    logic [RegAw-1:0]    ra;
    logic [RegAw-1:0]    rb;
    logic [ImmW-1:0]     imm;
    stop_reason_e        reason;
    logic [OffBits-1:0]  offset;
  } cmd_t;

  typedef struct packed {
    logic [OffBits-1:0]  offset;
    stop_reason_e        reason;
    logic [RegW-1:0]     value;
  } result_t;

  function automatic logic [2:0] instr_len(input logic [7:0] op);
    logic [2:0] len;
    if (op == OpcLoad) begin
      len = 3'd6;
    end else if (op == OpcAdd || op == OpcSub || op == OpcMul) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

// ===== hdl/brvm_ram.sv =====
module brvm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/brvm_front.sv =====
module brvm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [7:0]        code_byte_i,
  input  logic              last_byte_i,
  output logic              cmd_push_o,
  output brvm_pkg::cmd_t    cmd_o,
  input  logic              q_full_i
);

  logic                          acc;
  logic                          stop_q, stop_d;
  logic [2:0]                    pos_q, pos_d, pos_inc;
  logic [7:0]                    op_q, op_d;
  logic [brvm_pkg::OffBits-1:0]  off_q, off_d, off_fin;
  logic [7:0]                    opnd_q [brvm_pkg::OperandN];
  logic                          opnd_we;
  logic [1:0]                    opnd_idx;
  logic                          exec, fin;
  brvm_pkg::stop_reason_e        reason;
  brvm_pkg::alu_op_e             alu_op;

  assign byte_ready_o = !q_full_i;
  assign acc          = byte_valid_i && byte_ready_o;
  assign pos_inc      = 3'(pos_q + 3'd1);
  assign opnd_idx     = 2'(pos_q - 3'd1);

  always_comb begin
    stop_d  = stop_q;
    pos_d   = pos_q;
    op_d    = op_q;
    off_d   = off_q;
    exec    = 1'b0;
    fin     = 1'b0;
    opnd_we = 1'b0;
    off_fin = off_q;
    reason  = brvm_pkg::StopEnd;
    if (acc) begin
      if (!stop_q) begin
        if (off_q != {brvm_pkg::OffBits{1'b1}}) begin
          off_d = off_q + 1'b1;
        end
        if (pos_q == 3'd0) begin
          op_d = code_byte_i;
          if (code_byte_i == brvm_pkg::OpcNop) begin
            pos_d = 3'd0;
          end else if (brvm_pkg::instr_len(code_byte_i) > 3'd1) begin
            pos_d = 3'd1;
          end else begin
            stop_d = 1'b1;
          end
        end else begin
          opnd_we = (pos_q <= 3'(brvm_pkg::OperandN));
          if (pos_inc >= brvm_pkg::instr_len(op_q)) begin
            exec  = 1'b1;
            pos_d = 3'd0;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
      if (last_byte_i) begin
        fin     = 1'b1;
        off_fin = off_d;
        if (stop_d) begin
          reason = (op_d == brvm_pkg::OpcHalt) ? brvm_pkg::StopHalt
                                               : brvm_pkg::StopUnknown;
        end else if (pos_d != 3'd0) begin
          reason = brvm_pkg::StopTrunc;
        end else begin
          reason = brvm_pkg::StopEnd;
        end
        // back to reset state for the next program
        stop_d = 1'b0;
        pos_d  = 3'd0;
        op_d   = '0;
        off_d  = '0;
      end
    end
  end

  always_comb begin
    if (op_q == brvm_pkg::OpcLoad) begin
      alu_op = brvm_pkg::AluLoad;
    end else if (op_q == brvm_pkg::OpcAdd) begin
      alu_op = brvm_pkg::AluAdd;
    end else if (op_q == brvm_pkg::OpcSub) begin
      alu_op = brvm_pkg::AluSub;
    end else begin
      alu_op = brvm_pkg::AluMul;
    end
  end

  // the final byte of an instruction goes straight into the entry
  always_comb begin
    cmd_push_o     = exec || fin;
    cmd_o.do_exec  = exec;
    cmd_o.do_fin   = fin;
    cmd_o.op       = alu_op;
    cmd_o.rd       = opnd_q[0][brvm_pkg::RegAw-1:0];
    cmd_o.ra       = opnd_q[1][brvm_pkg::RegAw-1:0];
    cmd_o.rb       = code_byte_i[brvm_pkg::RegAw-1:0];
    cmd_o.imm      = {code_byte_i, opnd_q[3], opnd_q[2], opnd_q[1]};
    cmd_o.reason   = reason;
    cmd_o.offset   = off_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
      pos_q  <= 3'd0;
      op_q   <= '0;
      off_q  <= '0;
    end else begin
      stop_q <= stop_d;
      pos_q  <= pos_d;
      op_q   <= op_d;
      off_q  <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opnd_we) begin
      opnd_q[opnd_idx] <= code_byte_i;
    end
  end

endmodule

// ===== hdl/brvm_queue.sv =====
module brvm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brvm_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output brvm_pkg::cmd_t  head_o
);

  brvm_pkg::cmd_t          mem_q [brvm_pkg::QDepth];
  logic [brvm_pkg::QAw-1:0] wptr_q, rptr_q;
  logic [brvm_pkg::QAw:0]   cnt_q;
  logic                     do_push, do_pop;

  assign full_o  = (cnt_q == (brvm_pkg::QAw+1)'(brvm_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/brvm_back.sv =====
module brvm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  brvm_pkg::cmd_t    q_head_i,
  output logic              q_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output brvm_pkg::result_t res_o
);

  localparam int unsigned Hw = brvm_pkg::RegW / 2;

  brvm_pkg::back_state_e         state_q, state_d;
  brvm_pkg::cmd_t                cur_q;
  logic [brvm_pkg::RegCount-1:0] vld_q, vld_d;
  logic [brvm_pkg::RegW-1:0]     r0_q, r0_d;
  logic                          a_vld_q, b_vld_q;
  logic [brvm_pkg::RegW-1:0]     rd_a, rd_b, opa, opb;
  logic                          we;
  logic [brvm_pkg::RegW-1:0]     wdata;
  logic [brvm_pkg::RegW-1:0]     p0_q, p1_full, p2_full;
  logic [Hw-1:0]                 p1_q, p2_q;
  logic                          mul_ld;
  logic                          out_ld;
  logic                          out_vld_q;
  brvm_pkg::result_t             out_q;

  brvm_ram #(
    .Width (brvm_pkg::RegW),
    .Depth (brvm_pkg::RegCount)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (cur_q.rd),
    .wdata_i   (wdata),
    .raddr_a_i (q_head_i.ra),
    .raddr_b_i (q_head_i.rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // a register not written since the program began reads as zero
  assign opa     = a_vld_q ? rd_a : '0;
  assign opb     = b_vld_q ? rd_b : '0;
  assign p1_full = opa[Hw-1:0] * opb[brvm_pkg::RegW-1:Hw];
  assign p2_full = opa[brvm_pkg::RegW-1:Hw] * opb[Hw-1:0];

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    we      = 1'b0;
    wdata   = '0;
    mul_ld  = 1'b0;
    out_ld  = 1'b0;
    vld_d   = vld_q;
    r0_d    = r0_q;
    unique case (state_q)
      brvm_pkg::BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = q_head_i.do_exec ? brvm_pkg::BkExec : brvm_pkg::BkFinish;
        end
      end
      brvm_pkg::BkExec: begin
        unique case (cur_q.op)
          brvm_pkg::AluLoad: begin
            we    = 1'b1;
            wdata = brvm_pkg::RegW'(cur_q.imm);
          end
          brvm_pkg::AluAdd: begin
            we    = 1'b1;
            wdata = opa + opb;
          end
          brvm_pkg::AluSub: begin
            we    = 1'b1;
            wdata = opa - opb;
          end
          brvm_pkg::AluMul: begin
            mul_ld = 1'b1;
          end
          default: ;
        endcase
        if (cur_q.op == brvm_pkg::AluMul) begin
          state_d = brvm_pkg::BkMulWb;
        end else begin
          state_d = cur_q.do_fin ? brvm_pkg::BkFinish : brvm_pkg::BkIdle;
        end
      end
      brvm_pkg::BkMulWb: begin
        we      = 1'b1;
        wdata   = p0_q + {Hw'(p1_q + p2_q), Hw'(0)};
        state_d = cur_q.do_fin ? brvm_pkg::BkFinish : brvm_pkg::BkIdle;
      end
      brvm_pkg::BkFinish: begin
        if (!out_vld_q || res_ready_i) begin
          out_ld  = 1'b1;
          state_d = brvm_pkg::BkIdle;
        end
      end
      default: state_d = brvm_pkg::BkIdle;
    endcase
    if (we) begin
      vld_d[cur_q.rd] = 1'b1;
      if (cur_q.rd == '0) begin
        r0_d = wdata;
      end
    end
    if (out_ld) begin
      vld_d = '0;
      r0_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= brvm_pkg::BkIdle;
      vld_q     <= '0;
      r0_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      r0_q    <= r0_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_vld_q <= vld_q[q_head_i.ra];
    b_vld_q <= vld_q[q_head_i.rb];
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
    if (mul_ld) begin
      p0_q <= opa[Hw-1:0] * opb[Hw-1:0];
      p1_q <= p1_full[Hw-1:0];
      p2_q <= p2_full[Hw-1:0];
    end
    if (out_ld) begin
      out_q.value  <= r0_q;
      out_q.reason <= cur_q.reason;
      out_q.offset <= cur_q.offset;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// ===== hdl/bytecode_register_vm_core.sv =====
// takes one code byte per cycle; the front stalls only when the four-entry queue is full
// back end: pop in idle, run in exec, mul write-back for a mul, finish for a program end
// finish loads the result into the output register once any earlier one is taken;
// output register decouples the result; bytes of the next program flow on meanwhile
// rst_ni is asynchronous and clears all control state and the register valid bits;
// no clearing pass, the register file is cleared by valid bits at each program end
module bytecode_register_vm_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [brvm_pkg::InTdataW-1:0]  s_axis_tdata_i,  // [7:0] code_byte
  input  logic                           s_axis_tlast_i,  // last_byte
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [brvm_pkg::OutTdataW-1:0] m_axis_tdata_o   // result_value, stop_reason,
                                                          // stop_offset, zero pad
);

  logic              cmd_push, q_full, q_valid, q_pop;
  brvm_pkg::cmd_t    cmd, q_head;
  brvm_pkg::result_t res;

  brvm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .code_byte_i  (s_axis_tdata_i),
    .last_byte_i  (s_axis_tlast_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd),
    .q_full_i     (q_full)
  );

  brvm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  brvm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = brvm_pkg::OutTdataW'(res);

endmodule

// ===== hdl/brvm_checker.sv =====
module brvm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [brvm_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned OffLo = brvm_pkg::RegW + 2;

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // every program consumes at least its marked byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OffLo +: brvm_pkg::OffBits] != '0)
    else $error("stop offset of zero reported");

  // pad bits above the fields stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[brvm_pkg::OutTdataW-1:brvm_pkg::OutFieldW] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind bytecode_register_vm_core brvm_checker u_brvm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
